// ===== hdl/unsigned_and_interval_bounds_assert.svh =====
// Assertion macros shared by the interval bounds block.
`ifndef UNSIGNED_AND_INTERVAL_BOUNDS_ASSERT_SVH
`define UNSIGNED_AND_INTERVAL_BOUNDS_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define UAIB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define UAIB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/uaib_pkg.sv =====
package uaib_pkg;

  // Width of every request and result field
  localparam int FIELD_W = 32;

  typedef logic [FIELD_W-1:0] field_t;

endpackage

// ===== hdl/uaib_in_if.sv =====
// Request channel: two unsigned intervals
interface uaib_in_if;
  import uaib_pkg::*;

  logic   valid;
  logic   ready;
  field_t lo_a;
  field_t hi_a;
  field_t lo_b;
  field_t hi_b;

  modport source (output valid, output lo_a, output hi_a, output lo_b, output hi_b,
                  input ready);
  modport sink   (input valid, input lo_a, input hi_a, input lo_b, input hi_b,
                  output ready);
endinterface

// ===== hdl/uaib_out_if.sv =====
// Result channel: bounds of the AND
interface uaib_out_if;
  import uaib_pkg::*;

  logic   valid;
  logic   ready;
  field_t lo_out;
  field_t hi_out;

  modport source (output valid, output lo_out, output hi_out, input ready);
  modport sink   (input valid, input lo_out, input hi_out, output ready);
endinterface

// ===== hdl/unsigned_and_interval_bounds.sv =====
// Tightest unsigned interval [lo_out, hi_out] holding x AND y for every x in
// [lo_a, hi_a] and y in [lo_b, hi_b], computed on the low WIDTH bits of each
// field (zero-extended when WIDTH exceeds 32, results cut to 32 bits).
// Inverted intervals are not flagged; the bit searches run on them as given.
// The block is a three-stage pipeline: stage one evaluates, for every bit
// position at once, whether raising a lower bound or lowering an upper bound
// at that bit stays inside its interval; stage two picks the most
// significant such bit; stage three builds the bounds into the output
// register. A request accepted into the stage-one registers moves through
// the stage-two registers into the output register, where its result waits
// to be taken; one request is accepted every cycle while results are taken.
// A stalled output holds each stage in place without loss.
`include "unsigned_and_interval_bounds_assert.svh"

module unsigned_and_interval_bounds #(
  parameter int WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  uaib_in_if.sink    in_req,
  uaib_out_if.source out_res
);
  import uaib_pkg::*;

  typedef logic [WIDTH-1:0] word_t;

  // Pipeline handshake
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3_r || out_res.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_req.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_req.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage 1: per-bit candidate tests
  word_t a_in, b_in, c_in, d_in;
  word_t lo_hit_nxt, lo_kind_nxt, hi_hit_nxt, hi_kind_nxt;

  assign a_in = WIDTH'(in_req.lo_a);
  assign b_in = WIDTH'(in_req.hi_a);
  assign c_in = WIDTH'(in_req.lo_b);
  assign d_in = WIDTH'(in_req.hi_b);

  always_comb begin
    word_t bit_m, low_m, ta, tc, tb, td;
    logic  ta_ok, tc_ok, tb_ok, td_ok;
    bit_m = '0;
    low_m = '0;
    ta    = '0;
    tc    = '0;
    tb    = '0;
    td    = '0;
    lo_hit_nxt  = '0;
    lo_kind_nxt = '0;
    hi_hit_nxt  = '0;
    hi_kind_nxt = '0;
    for (int i = 0; i < WIDTH; i++) begin
      bit_m = WIDTH'(1) << i;
      low_m = bit_m - WIDTH'(1);
      // raise a lower bound to the next value with this bit set
      ta = (a_in | bit_m) & ~low_m;
      tc = (c_in | bit_m) & ~low_m;
      ta_ok = !a_in[i] && !c_in[i] && (ta <= b_in);
      tc_ok = !a_in[i] && !c_in[i] && (tc <= d_in);
      lo_hit_nxt[i]  = ta_ok || tc_ok;
      lo_kind_nxt[i] = ta_ok;
      // clear this bit of an upper bound and fill below it
      tb = (b_in & ~bit_m) | low_m;
      td = (d_in & ~bit_m) | low_m;
      tb_ok = b_in[i] && !d_in[i] && (tb >= a_in);
      td_ok = !b_in[i] && d_in[i] && (td >= c_in);
      hi_hit_nxt[i]  = tb_ok || td_ok;
      hi_kind_nxt[i] = tb_ok;
    end
  end

  word_t a1_r, b1_r, c1_r, d1_r;
  word_t lo_hit_r, lo_kind_r, hi_hit_r, hi_kind_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      a1_r      <= a_in;
      b1_r      <= b_in;
      c1_r      <= c_in;
      d1_r      <= d_in;
      lo_hit_r  <= lo_hit_nxt;
      lo_kind_r <= lo_kind_nxt;
      hi_hit_r  <= hi_hit_nxt;
      hi_kind_r <= hi_kind_nxt;
    end
  end

  // Stage 2: most significant hit, as a prefix mask and a one-hot bit
  word_t lo_pre_nxt, hi_pre_nxt, lo_oh_nxt, hi_oh_nxt;

  always_comb begin
    for (int i = 0; i < WIDTH; i++) begin
      lo_pre_nxt[i] = |(lo_hit_r >> i);
      hi_pre_nxt[i] = |(hi_hit_r >> i);
    end
  end

  assign lo_oh_nxt = lo_hit_r & ~(lo_pre_nxt >> 1);
  assign hi_oh_nxt = hi_hit_r & ~(hi_pre_nxt >> 1);

  word_t a2_r, b2_r, c2_r, d2_r;
  word_t lo_pre_r, hi_pre_r, lo_oh_r, hi_oh_r;
  logic  lo_from_a_r, hi_from_b_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      a2_r        <= a1_r;
      b2_r        <= b1_r;
      c2_r        <= c1_r;
      d2_r        <= d1_r;
      lo_pre_r    <= lo_pre_nxt;
      hi_pre_r    <= hi_pre_nxt;
      lo_oh_r     <= lo_oh_nxt;
      hi_oh_r     <= hi_oh_nxt;
      lo_from_a_r <= |(lo_oh_nxt & lo_kind_r);
      hi_from_b_r <= |(hi_oh_nxt & hi_kind_r);
    end
  end

  // Stage 3: apply the chosen adjustment; no hit leaves the bounds as given
  word_t ta3, tc3, tb3, td3, below3, lo_w, hi_w;

  assign ta3    = (a2_r & ~lo_pre_r) | lo_oh_r;
  assign tc3    = (c2_r & ~lo_pre_r) | lo_oh_r;
  assign below3 = hi_pre_r & ~hi_oh_r;
  assign tb3    = (b2_r & ~hi_pre_r) | below3;
  assign td3    = (d2_r & ~hi_pre_r) | below3;
  assign lo_w   = lo_from_a_r ? (ta3 & c2_r) : (a2_r & tc3);
  assign hi_w   = hi_from_b_r ? (tb3 & d2_r) : (b2_r & td3);

  field_t lo_out_r, hi_out_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      lo_out_r <= FIELD_W'(lo_w);
      hi_out_r <= FIELD_W'(hi_w);
    end
  end

  assign out_res.valid  = v3_r;
  assign out_res.lo_out = lo_out_r;
  assign out_res.hi_out = hi_out_r;

  // Checks
  `UAIB_ASSERT_NOW(a_lo_onehot, clk, rst_n, v2_r, $onehot0(lo_oh_r), "lower select not one-hot")
  `UAIB_ASSERT_NOW(a_hi_onehot, clk, rst_n, v2_r, $onehot0(hi_oh_r), "upper select not one-hot")
  `UAIB_ASSERT_NOW(a_full_stall, clk, rst_n, !in_req.ready, v1_r && v2_r && v3_r, "stage free")
  `UAIB_ASSERT_NEXT(a_advance, clk, rst_n, v1_r && rdy2, v2_r, "stage 1 request lost")

endmodule

// ===== test/uaib_bounds_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts the AND bounds for every accepted request
// and compares each accepted result with the oldest prediction.
module uaib_bounds_checker #(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  uaib_in_if   in_ch,
  uaib_out_if  out_ch,
  output int   fail_count,
  output int   outstanding
);
  import uaib_pkg::*;

  typedef struct packed {
    field_t lo;
    field_t hi;
  } bounds_t;

  bounds_t bounds_due[$];

  // All ones over the low WIDTH bits; wraps cleanly at 64
  function automatic logic [63:0] span_mask();
    return (64'd2 << (WIDTH - 1)) - 64'd1;
  endfunction

  // Field reduced to the block's width
  function automatic logic [63:0] narrow(field_t v);
    return {32'b0, v} & span_mask();
  endfunction

  // Least AND: raise one lower bound at the top bit clear in both where that raise fits
  function automatic field_t and_floor(logic [63:0] a, logic [63:0] b,
                                       logic [63:0] c, logic [63:0] d);
    logic [63:0] wm;
    logic [63:0] probe;
    logic [63:0] t;
    bit          found;
    wm    = span_mask();
    found = 1'b0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      probe = 64'd1 << i;
      if (!found && (~a & ~c & probe & wm) != 64'd0) begin
        t = (a | probe) & ((64'd0 - probe) & wm);
        if (t <= b) begin
          a     = t;
          found = 1'b1;
        end else begin
          t = (c | probe) & ((64'd0 - probe) & wm);
          if (t <= d) begin
            c     = t;
            found = 1'b1;
          end
        end
      end
    end
    return field_t'(a & c & wm);
  endfunction

  // Greatest AND: drop a bit set in one upper bound only, fill below it
  function automatic field_t and_ceiling(logic [63:0] a, logic [63:0] b,
                                         logic [63:0] c, logic [63:0] d);
    logic [63:0] wm;
    logic [63:0] probe;
    logic [63:0] t;
    bit          found;
    wm    = span_mask();
    found = 1'b0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      probe = 64'd1 << i;
      if (!found && (b & ~d & probe & wm) != 64'd0) begin
        t = ((b & ~probe) | (probe - 64'd1)) & wm;
        if (t >= a) begin
          b     = t;
          found = 1'b1;
        end
      end else if (!found && (~b & d & probe & wm) != 64'd0) begin
        t = ((d & ~probe) | (probe - 64'd1)) & wm;
        if (t >= c) begin
          d     = t;
          found = 1'b1;
        end
      end
    end
    return field_t'(b & d & wm);
  endfunction

  // Request in -> prediction queued; result out -> compared with oldest
  always @(posedge clk) begin : watch
    bounds_t want;
    if (!rst_n) begin
      bounds_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        want.lo = and_floor(narrow(in_ch.lo_a), narrow(in_ch.hi_a),
                            narrow(in_ch.lo_b), narrow(in_ch.hi_b));
        want.hi = and_ceiling(narrow(in_ch.lo_a), narrow(in_ch.hi_a),
                              narrow(in_ch.lo_b), narrow(in_ch.hi_b));
        bounds_due.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (bounds_due.size() == 0) begin
          $error("unexpected result: lo_out %h hi_out %h", out_ch.lo_out, out_ch.hi_out);
          fail_count++;
        end else begin
          want = bounds_due.pop_front();
          if (out_ch.lo_out !== want.lo) begin
            $error("lo_out mismatch: expected %h, actual %h", want.lo, out_ch.lo_out);
            fail_count++;
          end
          if (out_ch.hi_out !== want.hi) begin
            $error("hi_out mismatch: expected %h, actual %h", want.hi, out_ch.hi_out);
            fail_count++;
          end
        end
      end
    end
    outstanding = bounds_due.size();
  end

endmodule

// ===== test/tb_unsigned_and_interval_bounds.sv =====
`timescale 1ns / 1ps

module tb_unsigned_and_interval_bounds;
  import uaib_pkg::*;

  localparam int WIDTH = 32;

  logic clk;
  logic rst_n;

  int fail_count;
  int outstanding;

  // Idling controls, changed from phase to phase
  int gap_pct;
  int stall_pct;
  bit tail_phase;

  uaib_in_if  in_ch ();
  uaib_out_if out_ch ();

  unsigned_and_interval_bounds #(.WIDTH(WIDTH)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch)
  );

  uaib_bounds_checker #(.WIDTH(WIDTH)) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Safety net against a hung handshake
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: random stall bursts, none in the tail
  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!tail_phase && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Offer one request, hold it until taken, then maybe idle a while
  task automatic send_bounds(field_t la, field_t ha, field_t lb, field_t hb);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.lo_a  <= la;
    in_ch.hi_a  <= ha;
    in_ch.lo_b  <= lb;
    in_ch.hi_b  <= hb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!tail_phase && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Values biased towards bit boundaries and sparse / dense patterns
  function automatic field_t pick_value();
    int k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 6))
      0, 1: return field_t'($urandom);
      2: return field_t'($urandom_range(0, 64));
      3: return ~field_t'($urandom_range(0, 64));
      4: return (field_t'(1) << k) + field_t'($urandom_range(0, 2)) - field_t'(1);
      5: return field_t'($urandom & $urandom);
      default: return field_t'($urandom | $urandom);
    endcase
  endfunction

  // Mostly ordered intervals; some narrow, single-point or inverted
  task automatic pick_span(output field_t lo, output field_t hi);
    field_t u;
    field_t v;
    u = pick_value();
    v = pick_value();
    case ($urandom_range(0, 9))
      7: begin
        lo = u;
        hi = u + field_t'($urandom_range(0, 300));
      end
      8: begin
        lo = u;
        hi = u;
      end
      9: begin
        lo = (u > v) ? u : v;
        hi = (u > v) ? v : u;
      end
      default: begin
        lo = (u < v) ? u : v;
        hi = (u < v) ? v : u;
      end
    endcase
  endtask

  initial begin : stimulus
    field_t la, ha, lb, hb;
    gap_pct     = 30;
    stall_pct   = 20;
    tail_phase  = 1'b0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.lo_a  <= '0;
    in_ch.hi_a  <= '0;
    in_ch.lo_b  <= '0;
    in_ch.hi_b  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, full and point intervals, inverted intervals,
    // raises that fail on the first bound and land on the second
    send_bounds(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_bounds(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_bounds(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0005);
    send_bounds(32'h0000_0005, 32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFF);
    send_bounds(32'h0000_000C, 32'h0000_000F, 32'h0000_0003, 32'h0000_0003);
    send_bounds(32'h0000_000A, 32'h0000_0002, 32'h0000_0007, 32'h0000_0001);
    send_bounds(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_bounds(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    send_bounds(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_bounds(32'h0000_0001, 32'h0000_0002, 32'h0000_0004, 32'h0000_0008);
    send_bounds(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
    send_bounds(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_bounds(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001);
    send_bounds(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bounds(32'h0000_0000, 32'h0001_0000, 32'h0000_FFFF, 32'h0002_0000);
    send_bounds(32'h0000_0003, 32'h0000_0004, 32'h0000_0001, 32'h0000_0002);
    send_bounds(32'h0000_0006, 32'h0000_0007, 32'h0000_0000, 32'h0000_0008);
    send_bounds(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE);
    send_bounds(32'hF0F0_F0F0, 32'hF0F0_F0FF, 32'h0F0F_0F0F, 32'h0F0F_0FFF);
    send_bounds(32'h1234_5678, 32'h8765_4321, 32'h0000_FFFF, 32'hFFFF_0000);
    drain();

    // Random phases with differing idle density; a full drain halfway
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 20; stall_pct = 15; end
        2: begin gap_pct = 50; stall_pct = 40; end
        default: begin gap_pct = 10; stall_pct = 5; end
      endcase
      for (int n = 0; n < 300; n++) begin
        pick_span(la, ha);
        pick_span(lb, hb);
        send_bounds(la, ha, lb, hb);
      end
      if (phase == 1) drain();
    end

    // Tail: back-to-back requests, results taken every cycle
    tail_phase = 1'b1;
    for (int n = 0; n < 150; n++) begin
      pick_span(la, ha);
      pick_span(lb, hb);
      send_bounds(la, ha, lb, hb);
    end
    in_ch.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
